### rtl/mer_pkg.sv
// shared widths, request types, microcode fields and the microcode rom of the ellipse rasterizer
package mer_pkg;

  localparam int COORD_BITS = 10;
  localparam int OFFX_W     = COORD_BITS + 1;
  localparam int PIX_W      = COORD_BITS + 2;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DEC_BITS   = 48;
  localparam int MA_W       = 3 * COORD_BITS + 3;
  localparam int MB_W       = 2 * COORD_BITS + 2;
  localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((2 * PIX_W + 7) / 8) * 8;
  localparam int UPC_W      = 5;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // snapshot handed from the sequencer to the pixel emitter
  typedef struct packed {
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
    logic [OFFX_W-1:0]       offx;
    logic signed [PIX_W-1:0] offy;
    logic                    done;
  } emit_req_t;

  typedef enum logic [2:0] {
    MA_RXIN, MA_RYIN, MA_RX2, MA_RY2, MA_YM, MA_PROD
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_RXIN, MB_RYIN, MB_RY2, MB_OFFX, MB_OFFY, MB_TX, MB_YM, MB_PROD
  } mul_b_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [1:0] {SRC_PROD, SRC_RX2, SRC_RY2} acc_src_t;
  typedef enum logic [1:0] {SH0, SH2, SH3} acc_sh_t;

  typedef enum logic [2:0] {
    CND_NEVER, CND_INACTIVE, CND_REGION2, CND_R1_EXIT, CND_DEC_NEG, CND_DEC_LE0, CND_OFFY_NEG
  } cond_t;

  typedef enum logic [1:0] {EM_NONE, EM_PIX, EM_DONE} emit_t;

  // microcode addresses
  typedef enum logic [UPC_W-1:0] {
    U_ST0, U_ST1, U_ST2, U_ST3, U_ST4,
    U_STEP, U_R1_TEST0, U_R1_TEST1, U_R1_CHECK,
    U_R1_EMIT, U_R1_MUL, U_R1_POS0, U_R1_POS1, U_R1_POS2, U_R1_NEG0, U_R1_NEG1,
    U_EN0, U_EN1, U_EN2, U_EN3, U_EN4, U_EN5,
    U_R2, U_R2_EMIT, U_R2_MUL, U_R2_POS0, U_R2_POS1, U_R2_NEG0, U_R2_NEG1, U_R2_NEG2,
    U_DONE
  } upc_t;

  typedef struct packed {
    logic     mul_en;
    mul_a_t   a_sel;
    mul_b_t   b_sel;
    acc_op_t  acc_op;
    acc_src_t acc_src;
    acc_sh_t  acc_sh;
    logic     ld_rx2;
    logic     ld_ry2;
    logic     ld_tmp;
    logic     offx_inc;
    logic     offy_dec;
    logic     set_r2;
    logic     clr_active;
    emit_t    emit;
    cond_t    cond;
    upc_t     target;
    logic     fin;
  } ucw_t;

  function automatic ucw_t ucode(input upc_t pc);
    ucw_t w;
    begin
      w = '0;
      unique case (pc)
        // start: squares of the radii and the region 1 decision
        U_ST0: begin
          w.mul_en = 1'b1; w.a_sel = MA_RXIN; w.b_sel = MB_RXIN;
        end
        U_ST1: begin
          w.ld_rx2 = 1'b1;
          w.mul_en = 1'b1; w.a_sel = MA_RYIN; w.b_sel = MB_RYIN;
        end
        U_ST2: begin
          w.ld_ry2 = 1'b1;
          w.mul_en = 1'b1; w.a_sel = MA_RX2; w.b_sel = MB_RYIN;
          w.acc_op = ACC_LOAD; w.acc_src = SRC_RX2; w.acc_sh = SH0;
        end
        U_ST3: begin
          w.acc_op = ACC_SUB; w.acc_src = SRC_PROD; w.acc_sh = SH2;
        end
        U_ST4: begin
          w.acc_op = ACC_ADD; w.acc_src = SRC_RY2; w.acc_sh = SH2;
          w.fin = 1'b1;
        end
        // step: dispatch, region 1 slope test, emit and decision update
        U_STEP: begin
          w.cond = CND_INACTIVE; w.target = U_DONE;
        end
        U_R1_TEST0: begin
          w.cond = CND_REGION2; w.target = U_R2;
          w.mul_en = 1'b1; w.a_sel = MA_RY2; w.b_sel = MB_OFFX;
        end
        U_R1_TEST1: begin
          w.ld_tmp = 1'b1;
          w.mul_en = 1'b1; w.a_sel = MA_RX2; w.b_sel = MB_OFFY;
        end
        U_R1_CHECK: begin
          w.cond = CND_R1_EXIT; w.target = U_EN0;
        end
        U_R1_EMIT: begin
          w.emit = EM_PIX; w.offx_inc = 1'b1;
        end
        U_R1_MUL: begin
          w.mul_en = 1'b1; w.a_sel = MA_RY2; w.b_sel = MB_OFFX;
          w.cond = CND_DEC_NEG; w.target = U_R1_NEG0;
        end
        U_R1_POS0: begin
          w.offy_dec = 1'b1;
          w.acc_op = ACC_ADD; w.acc_src = SRC_PROD; w.acc_sh = SH3;
        end
        U_R1_POS1: begin
          w.mul_en = 1'b1; w.a_sel = MA_RX2; w.b_sel = MB_OFFY;
          w.acc_op = ACC_ADD; w.acc_src = SRC_RY2; w.acc_sh = SH2;
        end
        U_R1_POS2: begin
          w.acc_op = ACC_SUB; w.acc_src = SRC_PROD; w.acc_sh = SH3;
          w.fin = 1'b1;
        end
        U_R1_NEG0: begin
          w.acc_op = ACC_ADD; w.acc_src = SRC_PROD; w.acc_sh = SH3;
        end
        U_R1_NEG1: begin
          w.acc_op = ACC_ADD; w.acc_src = SRC_RY2; w.acc_sh = SH2;
          w.fin = 1'b1;
        end
        // region 2 entry decision
        U_EN0: begin
          w.mul_en = 1'b1; w.a_sel = MA_YM; w.b_sel = MB_YM;
        end
        U_EN1: begin
          w.mul_en = 1'b1; w.a_sel = MA_RX2; w.b_sel = MB_PROD;
        end
        U_EN2: begin
          w.acc_op = ACC_LOAD; w.acc_src = SRC_PROD; w.acc_sh = SH2;
          w.mul_en = 1'b1; w.a_sel = MA_RX2; w.b_sel = MB_RY2;
        end
        U_EN3: begin
          w.acc_op = ACC_SUB; w.acc_src = SRC_PROD; w.acc_sh = SH2;
          w.mul_en = 1'b1; w.a_sel = MA_RY2; w.b_sel = MB_TX;
        end
        U_EN4: begin
          w.mul_en = 1'b1; w.a_sel = MA_PROD; w.b_sel = MB_TX;
        end
        U_EN5: begin
          w.acc_op = ACC_ADD; w.acc_src = SRC_PROD; w.acc_sh = SH0;
          w.set_r2 = 1'b1;
        end
        // region 2 step
        U_R2: begin
          w.cond = CND_OFFY_NEG; w.target = U_DONE;
        end
        U_R2_EMIT: begin
          w.emit = EM_PIX; w.offy_dec = 1'b1;
        end
        U_R2_MUL: begin
          w.mul_en = 1'b1; w.a_sel = MA_RX2; w.b_sel = MB_OFFY;
          w.cond = CND_DEC_LE0; w.target = U_R2_NEG0;
        end
        U_R2_POS0: begin
          w.acc_op = ACC_ADD; w.acc_src = SRC_RX2; w.acc_sh = SH2;
        end
        U_R2_POS1: begin
          w.acc_op = ACC_SUB; w.acc_src = SRC_PROD; w.acc_sh = SH3;
          w.fin = 1'b1;
        end
        U_R2_NEG0: begin
          w.offx_inc = 1'b1;
          w.acc_op = ACC_SUB; w.acc_src = SRC_PROD; w.acc_sh = SH3;
        end
        U_R2_NEG1: begin
          w.mul_en = 1'b1; w.a_sel = MA_RY2; w.b_sel = MB_OFFX;
          w.acc_op = ACC_ADD; w.acc_src = SRC_RX2; w.acc_sh = SH2;
        end
        U_R2_NEG2: begin
          w.acc_op = ACC_ADD; w.acc_src = SRC_PROD; w.acc_sh = SH3;
          w.fin = 1'b1;
        end
        U_DONE: begin
          w.emit = EM_DONE; w.clr_active = 1'b1; w.fin = 1'b1;
        end
        default: begin
          w.fin = 1'b1;
        end
      endcase
      return w;
    end
  endfunction

endpackage

### rtl/mer_pix_emit.sv
// pixel emitter: turns one point snapshot into four mirrored pixels or one done result
module mer_pix_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  mer_pkg::emit_req_t       req,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [mer_pkg::OUT_W-1:0] m_tdata,
  output logic                     m_tlast,
  output logic                     m_tuser
);
  import mer_pkg::*;

  localparam logic [1:0] LAST_BEAT = 2'd3;

  logic             busy;
  logic [1:0]       beat;
  emit_req_t        snap;
  logic             fire;
  logic             end_beat;
  logic [PIX_W-1:0] px_pos, px_neg, py_pos, py_neg, px, py;

  assign fire      = busy && m_tready;
  assign end_beat  = snap.done || (beat == LAST_BEAT);
  assign req_ready = !busy || (fire && end_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (req_valid && req_ready) begin
      busy <= 1'b1;
      beat <= '0;
    end else if (fire) begin
      if (end_beat) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      snap <= req;
    end
  end

  // beat bit 0 mirrors x, bit 1 mirrors y
  always_comb begin
    px_pos = PIX_W'(snap.cx) + PIX_W'(snap.offx);
    px_neg = PIX_W'(snap.cx) - PIX_W'(snap.offx);
    py_pos = PIX_W'(snap.cy) + snap.offy;
    py_neg = PIX_W'(snap.cy) - snap.offy;
    px     = snap.done ? '0 : (beat[0] ? px_neg : px_pos);
    py     = snap.done ? '0 : (beat[1] ? py_neg : py_pos);
  end

  assign m_tvalid = busy;
  assign m_tdata  = OUT_W'({py, px});
  assign m_tlast  = end_beat;
  assign m_tuser  = snap.done;

endmodule

### rtl/midpoint_ellipse_rasterizer_core.sv
// top level of the midpoint ellipse rasterizer: microcoded sequencer, datapath and pixel emitter
//
// A start request (tuser = 0) loads the center and both semi-axes; it gives no
// result. A step request (tuser = 1) gives the four mirrored pixels of the
// current point in the order (+x,+y), (-x,+y), (+x,-y), (-x,-y) with tlast on
// the fourth, then moves the decision on by one point; the step that leaves
// region 1 also forms the region 2 decision. A step with no ellipse active, or
// after the walk has dropped below the axis, gives one result with tuser (done)
// high, tlast high and zero pixels; the walk can also run out on the step that
// leaves region 1. The microcode runs one control word a cycle unless held at
// an emit word; the words drive a single shared signed multiplier (one product
// a word, registered) and one 48-bit accumulator for the decision. The four
// pixels of a point are sent by a separate emitter that holds a snapshot, so
// the output stream is drained while the next request is worked on; the
// sequencer only waits at its emit word when the previous group has not been
// fully taken.
module midpoint_ellipse_rasterizer_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [mer_pkg::IN_W-1:0]  s_tdata,  // center_x, center_y, radius_x, radius_y
  input  logic                      s_tuser,  // cmd
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [mer_pkg::OUT_W-1:0] m_tdata,  // pixel_x, pixel_y
  output logic                      m_tlast,  // last
  output logic                      m_tuser   // done_res
);
  import mer_pkg::*;

  // sequencer control
  logic busy;
  upc_t pc;
  upc_t pc_next;
  ucw_t w;
  logic stall;
  logic run;
  logic cond_hit;
  logic s_fire;

  // ellipse state
  logic                         active;
  logic                         region_two;
  logic [COORD_BITS-1:0]        cx, cy;
  logic [COORD_BITS-1:0]        rxin, ryin;
  logic [SQ_W-1:0]              rx2, ry2;
  logic [OFFX_W-1:0]            offx;
  logic signed [PIX_W-1:0]      offy;
  logic signed [DEC_BITS-1:0]   dec, dec_next;
  logic signed [DEC_BITS-1:0]   prod, tmp;

  // datapath operands
  logic signed [PIX_W:0]        ym;
  logic [PIX_W-1:0]             tx;
  logic signed [MA_W-1:0]       a_op;
  logic signed [MB_W-1:0]       b_op;
  logic signed [MA_W+MB_W-1:0]  mul_p;
  logic signed [DEC_BITS-1:0]   acc_in, acc_sh_val;

  // emitter handshake
  logic      req_valid;
  logic      req_ready;
  emit_req_t req;

  // input fields from the lowest bit up
  logic [COORD_BITS-1:0] in_cx, in_cy, in_rx, in_ry;
  assign in_cx = s_tdata[COORD_BITS-1:0];
  assign in_cy = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_rx = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_ry = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

  assign s_tready = !busy;
  assign s_fire   = s_tvalid && s_tready;

  // control word fetch; an emit word holds until the emitter takes the snapshot
  always_comb begin
    w     = ucode(pc);
    stall = (w.emit != EM_NONE) && !req_ready;
    run   = busy && !stall;
  end

  // jump conditions, all looked at before the word changes anything
  always_comb begin
    unique case (w.cond)
      CND_INACTIVE: cond_hit = !active;
      CND_REGION2:  cond_hit = region_two;
      CND_R1_EXIT:  cond_hit = offy[PIX_W-1] || (tmp > prod);
      CND_DEC_NEG:  cond_hit = dec[DEC_BITS-1];
      CND_DEC_LE0:  cond_hit = dec[DEC_BITS-1] || (dec == '0);
      CND_OFFY_NEG: cond_hit = offy[PIX_W-1];
      default:      cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? w.target : upc_t'(pc + UPC_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pc         <= U_ST0;
      active     <= 1'b0;
      region_two <= 1'b0;
    end else if (s_fire) begin
      busy <= 1'b1;
      if (s_tuser == CMD_START) begin
        pc         <= U_ST0;
        active     <= 1'b1;
        region_two <= 1'b0;
      end else begin
        pc <= U_STEP;
      end
    end else if (run) begin
      if (w.fin) begin
        busy <= 1'b0;
      end else begin
        pc <= pc_next;
      end
      if (w.set_r2) begin
        region_two <= 1'b1;
      end
      if (w.clr_active) begin
        active <= 1'b0;
      end
    end
  end

  // shared multiplier operands
  assign ym = {offy[PIX_W-1], offy} - (PIX_W+1)'(1);
  assign tx = {offx, 1'b1};

  always_comb begin
    unique case (w.a_sel)
      MA_RXIN: a_op = MA_W'(rxin);
      MA_RYIN: a_op = MA_W'(ryin);
      MA_RX2:  a_op = MA_W'(rx2);
      MA_RY2:  a_op = MA_W'(ry2);
      MA_YM:   a_op = MA_W'(ym);
      MA_PROD: a_op = MA_W'(prod);
      default: a_op = '0;
    endcase
    unique case (w.b_sel)
      MB_RXIN: b_op = MB_W'(rxin);
      MB_RYIN: b_op = MB_W'(ryin);
      MB_RY2:  b_op = MB_W'(ry2);
      MB_OFFX: b_op = MB_W'(offx);
      MB_OFFY: b_op = MB_W'(offy);
      MB_TX:   b_op = MB_W'(tx);
      MB_YM:   b_op = MB_W'(ym);
      MB_PROD: b_op = MB_W'(prod);
      default: b_op = '0;
    endcase
  end

  assign mul_p = a_op * b_op;

  // decision accumulator, wraps modulo 2^48
  always_comb begin
    unique case (w.acc_src)
      SRC_RX2: acc_in = DEC_BITS'(rx2);
      SRC_RY2: acc_in = DEC_BITS'(ry2);
      default: acc_in = prod;
    endcase
    unique case (w.acc_sh)
      SH2:     acc_sh_val = acc_in <<< 2;
      SH3:     acc_sh_val = acc_in <<< 3;
      default: acc_sh_val = acc_in;
    endcase
    unique case (w.acc_op)
      ACC_LOAD: dec_next = acc_sh_val;
      ACC_ADD:  dec_next = dec + acc_sh_val;
      ACC_SUB:  dec_next = dec - acc_sh_val;
      default:  dec_next = dec;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      rxin <= in_rx;
      ryin <= in_ry;
      if (s_tuser == CMD_START) begin
        cx   <= in_cx;
        cy   <= in_cy;
        offx <= '0;
        offy <= PIX_W'(in_ry);
      end
    end else if (run) begin
      if (w.mul_en) begin
        prod <= DEC_BITS'(mul_p);
      end
      if (w.ld_rx2) begin
        rx2 <= SQ_W'(prod);
      end
      if (w.ld_ry2) begin
        ry2 <= SQ_W'(prod);
      end
      if (w.ld_tmp) begin
        tmp <= prod;
      end
      if (w.offx_inc) begin
        offx <= offx + OFFX_W'(1);
      end
      if (w.offy_dec) begin
        offy <= offy - PIX_W'(1);
      end
      dec <= dec_next;
    end
  end

  // snapshot of the current point, taken before this word's updates land
  assign req_valid = busy && (w.emit != EM_NONE);
  always_comb begin
    req.cx   = cx;
    req.cy   = cy;
    req.offx = offx;
    req.offy = offy;
    req.done = (w.emit == EM_DONE);
  end

  mer_pix_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

### tb/midpoint_ellipse_rasterizer_core_tb.sv
// self-checking testbench for the midpoint ellipse rasterizer core
module midpoint_ellipse_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int ITEM_TARGET = 200;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             last;
    logic             done;
  } pixel_result_t;

  // walks the ellipse alongside the block and holds the pixels still owed
  class ellipse_scoreboard;
    pixel_result_t pending_pixels[$];
    int unsigned mismatches = 0;
    bit region_two = 1'b0;
    bit active = 1'b0;
    logic [OFFX_W-1:0] offx = '0;
    longint offy = 0;
    logic [DEC_BITS-1:0] decision = '0;
    logic [COORD_BITS-1:0] cx = '0;
    logic [COORD_BITS-1:0] cy = '0;
    logic [63:0] rx2 = '0;
    logic [63:0] ry2 = '0;

    function void push_pixel(longint x, longint y, bit last, bit done);
      pixel_result_t r;
      r.px = x[PIX_W-1:0];
      r.py = y[PIX_W-1:0];
      r.last = last;
      r.done = done;
      pending_pixels.push_back(r);
    endfunction

    // four mirrored pixels of the current point, last one flagged
    function void push_mirrors();
      longint x0, y0, ox;
      x0 = longint'(cx);
      y0 = longint'(cy);
      ox = longint'(offx);
      push_pixel(x0 + ox, y0 + offy, 1'b0, 1'b0);
      push_pixel(x0 - ox, y0 + offy, 1'b0, 1'b0);
      push_pixel(x0 + ox, y0 - offy, 1'b0, 1'b0);
      push_pixel(x0 - ox, y0 - offy, 1'b1, 1'b0);
    endfunction

    function void note_request(logic cmd, logic [COORD_BITS-1:0] in_cx,
                               logic [COORD_BITS-1:0] in_cy, logic [COORD_BITS-1:0] in_rx,
                               logic [COORD_BITS-1:0] in_ry);
      logic [63:0] rx, ry, tx;
      longint ym;
      rx = 64'(in_rx);
      ry = 64'(in_ry);
      if (cmd == CMD_START) begin
        cx = in_cx;
        cy = in_cy;
        rx2 = rx * rx;
        ry2 = ry * ry;
        offx = '0;
        offy = longint'(in_ry);
        decision = DEC_BITS'(4 * ry2 - 4 * rx2 * ry + rx2);
        region_two = 1'b0;
        active = 1'b1;
        return;
      end
      if (!active) begin
        push_pixel(0, 0, 1'b1, 1'b1);
        return;
      end
      if (!region_two) begin
        if (offy >= 0 && ry2 * offx <= rx2 * offy) begin
          push_mirrors();
          offx = offx + OFFX_W'(1);
          if (decision[DEC_BITS-1]) begin
            decision = DEC_BITS'(decision + 8 * ry2 * offx + 4 * ry2);
          end else begin
            offy = offy - 1;
            decision = DEC_BITS'(decision + 8 * ry2 * offx - 8 * rx2 * offy + 4 * ry2);
          end
          return;
        end
        // slope test failed: form the region 2 decision, then step on in region 2
        tx = 64'(2 * offx + 1);
        ym = offy - 1;
        decision = DEC_BITS'(ry2 * tx * tx + 4 * rx2 * (ym * ym) - 4 * rx2 * ry2);
        region_two = 1'b1;
      end
      if (offy < 0) begin
        active = 1'b0;
        push_pixel(0, 0, 1'b1, 1'b1);
        return;
      end
      push_mirrors();
      offy = offy - 1;
      if (!decision[DEC_BITS-1] && decision != 0) begin
        decision = DEC_BITS'(decision + 4 * rx2 - 8 * rx2 * offy);
      end else begin
        offx = offx + OFFX_W'(1);
        decision = DEC_BITS'(decision + 8 * ry2 * offx - 8 * rx2 * offy + 4 * rx2);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] tdata, logic tlast, logic tuser);
      pixel_result_t got, want;
      got.px = tdata[PIX_W-1:0];
      got.py = tdata[2*PIX_W-1:PIX_W];
      got.last = tlast;
      got.done = tuser;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: x=%0d y=%0d last=%0b done=%0b",
                   $signed(got.px), $signed(got.py), got.last, got.done);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.last !== want.last ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"pixel mismatch: want x=%0d y=%0d last=%0b done=%0b, ",
                    "got x=%0d y=%0d last=%0b done=%0b"},
                   $signed(want.px), $signed(want.py), want.last, want.done,
                   $signed(got.px), $signed(got.py), got.last, got.done);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;
  logic             m_tuser;

  ellipse_scoreboard tracker = new();
  int unsigned items_sent = 0;
  bit calm = 1'b0;  // no idling on either side while set

  midpoint_ellipse_rasterizer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return '0;
    if (roll < 25) return '1;
    return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
  endfunction

  task automatic send_request(input logic cmd, input logic [COORD_BITS-1:0] cx,
                              input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] rx,
                              input logic [COORD_BITS-1:0] ry);
    while (!calm && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {ry, rx, cy, cx};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(cmd, cx, cy, rx, ry);
    items_sent++;
  endtask

  // step fields are don't-care, so they carry random bits
  task automatic step_once();
    send_request(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic wait_drained();
    while (tracker.pending_pixels.size() != 0) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // start an ellipse and walk it, mostly to the end; large ones are cut short
  task automatic run_ellipse();
    int pick, max_steps, n;
    logic [COORD_BITS-1:0] rx, ry;
    pick = $urandom_range(0, 99);
    max_steps = 1000;
    if (pick < 60) begin
      rx = COORD_BITS'($urandom_range(0, 8));
      ry = COORD_BITS'($urandom_range(0, 8));
    end else if (pick < 80) begin
      rx = COORD_BITS'($urandom_range(0, 24));
      ry = COORD_BITS'($urandom_range(0, 24));
    end else begin
      rx = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      ry = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      max_steps = $urandom_range(4, 16);
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
    send_request(CMD_START, pick_coord(), pick_coord(), rx, ry);
    n = 0;
    while (tracker.active && n < max_steps) begin
      step_once();
      n++;
    end
    if ($urandom_range(0, 3) == 0) step_once();
  endtask

  // output side: random backpressure, result check on each accepted beat
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tlast, m_tuser);
      m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // watchdog: too long with no handshake on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: step with nothing started, zero radii, full-scale geometry
    // cut short by a restart, one flat and one thin ellipse at the borders
    step_once();
    send_request(CMD_START, '0, '0, '0, '0);
    repeat (4) step_once();
    send_request(CMD_START, '1, '1, '1, '1);
    repeat (3) step_once();
    send_request(CMD_START, '1, '0, 10'd2, 10'd1);
    repeat (6) step_once();
    send_request(CMD_START, '0, '1, 10'd0, 10'd2);
    repeat (4) step_once();
    wait_drained();

    // random: mostly whole walks, some noise requests in between
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 90 && items_sent < 140);
      if ($urandom_range(0, 99) < 15) begin
        send_request(1'($urandom_range(0, 1)), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom));
      end else begin
        run_ellipse();
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);

    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.pending_pixels.size() != 0)
      $display("results never arrived: %0d", tracker.pending_pixels.size());
    if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
